@@ rtl/sgf_pkg.sv @@
// Package for the separable Gabor filter: request/result structs and codes.
// No dependencies.
package sgf_pkg;

  localparam int unsigned RespW = 51;

  // Store sizes: the field widths of request_t are built for these.
  localparam int unsigned MAX_TAPS   = 31;
  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;

  typedef enum logic [1:0] {
    OP_LOAD_TAP   = 2'd0,
    OP_LOAD_PIXEL = 2'd1,
    OP_READ       = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  localparam logic [1:0] REG_TAP_COUNT    = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         bank;
    logic [4:0]         tap;
    logic signed [15:0] coefficient;
    logic [7:0]         pixel;
    logic [7:0]         col;
    logic [7:0]         row;
  } request_t;

  typedef struct packed {
    logic signed [RespW-1:0] response;
    logic [7:0]              out_col;
    logic [7:0]              out_row;
  } result_t;

endpackage

@@ rtl/separable_gabor_filter.sv @@
// Top level of the separable Gabor filter (real part).
// Depends on sgf_pkg.
//
// Channel   Direction  Handshake           Payload
// request   in         start & !busy       request_t
// result    out        done strobe, 1 cyc  result_t
// config    in         cfg_we              cfg_index, cfg_data
//
// Loads are written while idle and do not raise busy. A read walks both
// bank pairs with one shared multiplier operand: per pair, per row j, each of
// the n pixel taps is fetched (S_PIX) and then multiplied (S_MUL), and
// S_ROWTAP and S_ROWMUL fold the row and apply the vertical tap. An in-frame
// read holds busy through these states and S_DONE, then strobes done; a read
// outside the frame or with zero taps goes straight to S_DONE.
// Reset (rst, synchronous) clears the sequencer and config registers only;
// the stores are undefined until written. The receiver cannot stall.
module separable_gabor_filter
  import sgf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  request_t    request,
  output logic        busy,
  output logic        done,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned TAW = $clog2(4 * MAX_TAPS);
  localparam int unsigned LW  = 8 + 16 + 6 + 1;   // one row sum, 31 taps
  localparam int unsigned PW  = LW + 16;

  typedef enum logic [2:0] {S_IDLE, S_PIX, S_MUL, S_ROWTAP, S_ROWMUL, S_DONE} state_t;

  state_t state;
  logic [4:0] tap_count;
  logic [8:0] frame_width, frame_height;
  logic [4:0] n;
  logic [8:0] w_eff, h_eff;

  logic [7:0]  frame_mem [MAX_WIDTH*MAX_HEIGHT];
  logic signed [15:0] tap_mem [4*MAX_TAPS];

  logic [7:0]  cur_col, cur_row;
  logic        pair;           // 0: cos banks, 1: sin banks
  logic [5:0]  ci, cj;         // tap indices
  logic        in_frame;
  logic [7:0]  pix_q;
  logic signed [15:0] tap_q;
  logic signed [LW-1:0] line_acc;
  logic signed [RespW-1:0] total;
  logic signed [PW-1:0]   prod;

  // Saturated registers.
  assign n     = (tap_count > 5'(MAX_TAPS)) ? 5'(MAX_TAPS) : tap_count;
  assign w_eff = (frame_width  > 9'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : frame_width;
  assign h_eff = (frame_height > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : frame_height;

  // Pixel position for the current taps; signed with room for offsets.
  logic signed [10:0] px, py;
  logic [5:0] half;
  assign half = 6'(n >> 1);
  assign px = $signed({3'b0, cur_col}) + $signed({5'b0, half}) - $signed({5'b0, ci});
  assign py = $signed({3'b0, cur_row}) + $signed({5'b0, half}) - $signed({5'b0, cj});

  logic pos_ok;
  assign pos_ok = (px >= 0) && (py >= 0) && (px < $signed({2'b0, w_eff})) &&
                  (py < $signed({2'b0, h_eff}));

  logic [TAW-1:0] hidx, vidx;
  assign hidx = TAW'({pair, 1'b0}) * TAW'(MAX_TAPS) + TAW'(ci);
  assign vidx = TAW'({pair, 1'b1}) * TAW'(MAX_TAPS) + TAW'(cj);

  logic req_in_frame;
  assign req_in_frame = ({1'b0, request.col} < w_eff) && ({1'b0, request.row} < h_eff);

  assign busy = (state != S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count    <= 5'd9;
      frame_width  <= 9'd256;
      frame_height <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_COUNT:    tap_count    <= cfg_data[4:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && request.op == OP_LOAD_PIXEL && req_in_frame)
      frame_mem[{request.row[YW-1:0], request.col[XW-1:0]}] <= request.pixel;
    pix_q <= frame_mem[{py[YW-1:0], px[XW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && request.op == OP_LOAD_TAP &&
        request.tap < 5'(MAX_TAPS))
      tap_mem[TAW'(request.bank) * TAW'(MAX_TAPS) + TAW'(request.tap)] <=
        request.coefficient;
    tap_q <= tap_mem[(state == S_ROWTAP) ? vidx : hidx];
  end

  // Shared multiplier operand (pixel or row sum) times tap.
  logic signed [LW-1:0] mul_a;
  assign mul_a = (state == S_ROWMUL) ? line_acc :
                 (in_frame ? $signed({{(LW-8){1'b0}}, pix_q}) : '0);

  // Sequencer and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && request.op == OP_READ) begin
            cur_col <= request.col;
            cur_row <= request.row;
            result.out_col <= request.col;
            result.out_row <= request.row;
            total <= '0;
            line_acc <= '0;
            pair <= 1'b0;
            ci <= '0;
            cj <= '0;
            state <= (req_in_frame && n != 5'd0) ? S_PIX : S_DONE;
          end
        end
        S_PIX: begin          // pixel and tap read issued
          in_frame <= pos_ok;
          state <= S_MUL;
        end
        S_MUL: begin          // multiply registered next
          prod <= PW'(mul_a * tap_q);
          if (ci == 6'(n) - 6'd1) begin
            ci <= '0;
            state <= S_ROWTAP;
          end else begin
            ci <= ci + 6'd1;
            state <= S_PIX;
          end
          if (ci != 6'd0) line_acc <= line_acc + LW'(prod);
        end
        S_ROWTAP: begin       // fold last product, fetch vertical tap
          line_acc <= line_acc + LW'(prod);
          state <= S_ROWMUL;
        end
        S_ROWMUL: begin
          if (pair) total <= total - RespW'(mul_a * tap_q);
          else      total <= total + RespW'(mul_a * tap_q);
          line_acc <= '0;
          if (cj == 6'(n) - 6'd1) begin
            cj <= '0;
            if (pair) state <= S_DONE;
            else begin
              pair <= 1'b1;
              state <= S_PIX;
            end
          end else begin
            cj <= cj + 6'd1;
            state <= S_PIX;
          end
        end
        S_DONE: begin
          result.response <= total;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb_separable_gabor_filter.sv @@
// Self-checking testbench for separable_gabor_filter: loads taps and pixels,
// reads filtered responses and checks them against an in-bench predictor.
// Depends on sgf_pkg and the separable_gabor_filter RTL.
`timescale 1ns / 1ps

module tb_separable_gabor_filter;
  import sgf_pkg::*;

  localparam int NTAPS = 31;
  localparam int FW = 256;
  localparam int FH = 256;
  localparam int STALL_LIMIT = 40000;
  localparam int REQ_W = $bits(request_t);

  logic clk;
  logic rst;
  logic start;
  request_t request;
  logic busy;
  logic done;
  result_t result;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  separable_gabor_filter dut (
    .clk(clk), .rst(rst), .start(start), .request(request), .busy(busy),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: frame, tap banks and the register copies.
  logic [7:0] frame_mem [FW*FH];
  logic signed [15:0] tap_mem [4*NTAPS];
  int unsigned tap_reg;
  int unsigned width_reg;
  int unsigned height_reg;

  // Generator side: which pixels hold a known value, so that no read ever
  // touches an unwritten one.
  bit pel_known [FW*FH];

  request_t request_queue[$];
  result_t pending_responses[$];
  int unsigned idle_pct;
  int unsigned errors;
  int unsigned stall_cycles;
  bit took;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_w();
    return (width_reg > FW) ? FW : width_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg > FH) ? FH : height_reg;
  endfunction

  function automatic int unsigned eff_n();
    return (tap_reg > NTAPS) ? NTAPS : tap_reg;
  endfunction

  function automatic longint pel_at(int x, int y);
    if (x < 0 || y < 0 || x >= int'(eff_w()) || y >= int'(eff_h())) return 0;
    return longint'(frame_mem[y*FW + x]);
  endfunction

  // One bank pair: vertical bank vb over horizontal bank hb.
  function automatic longint pair_sum(int hb, int vb, int c, int r);
    int n;
    int half;
    longint total;
    longint line;
    n = int'(eff_n());
    half = n / 2;
    total = 0;
    for (int j = 0; j < n; j++) begin
      line = 0;
      for (int i = 0; i < n; i++)
        line += longint'(tap_mem[hb*NTAPS + i]) * pel_at(c + half - i, r + half - j);
      total += longint'(tap_mem[vb*NTAPS + j]) * line;
    end
    return total;
  endfunction

  function automatic longint gabor_response(int c, int r);
    if (c >= int'(eff_w()) || r >= int'(eff_h())) return 0;
    return pair_sum(0, 1, c, r) - pair_sum(2, 3, c, r);
  endfunction

  // A read is safe when every in-frame pixel of its window is known.
  function automatic bit window_known(int c, int r);
    int n;
    int half;
    int x;
    int y;
    if (c >= int'(eff_w()) || r >= int'(eff_h())) return 1'b1;
    n = int'(eff_n());
    half = n / 2;
    for (int j = 0; j < n; j++)
      for (int i = 0; i < n; i++) begin
        x = c + half - i;
        y = r + half - j;
        if (x >= 0 && y >= 0 && x < int'(eff_w()) && y < int'(eff_h()))
          if (!pel_known[y*FW + x]) return 1'b0;
      end
    return 1'b1;
  endfunction

  // Apply one accepted request to the predictor.
  task automatic apply_request(input request_t rq);
    result_t exp_res;
    case (op_t'(rq.op))
      OP_LOAD_TAP: begin
        if (rq.tap < NTAPS) tap_mem[rq.bank*NTAPS + rq.tap] = rq.coefficient;
      end
      OP_LOAD_PIXEL: begin
        if (rq.col < eff_w() && rq.row < eff_h()) frame_mem[rq.row*FW + rq.col] = rq.pixel;
      end
      OP_READ: begin
        exp_res.response = RespW'(gabor_response(int'(rq.col), int'(rq.row)));
        exp_res.out_col = rq.col;
        exp_res.out_row = rq.row;
        pending_responses.push_back(exp_res);
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Generator helpers: build a request and queue it.
  task automatic push_tap(input int b, input int t, input logic [15:0] coef);
    request_t rq;
    rq = '0;
    rq.op = OP_LOAD_TAP;
    rq.bank = 2'(b);
    rq.tap = 5'(t);
    rq.coefficient = coef;
    rq.pixel = 8'($urandom);
    rq.col = 8'($urandom);
    rq.row = 8'($urandom);
    request_queue.push_back(rq);
  endtask

  task automatic push_pixel(input int c, input int r, input logic [7:0] val);
    request_t rq;
    rq = '0;
    rq.op = OP_LOAD_PIXEL;
    rq.bank = 2'($urandom);
    rq.tap = 5'($urandom);
    rq.coefficient = 16'($urandom);
    rq.pixel = val;
    rq.col = 8'(c);
    rq.row = 8'(r);
    if (c < int'(eff_w()) && r < int'(eff_h())) pel_known[r*FW + c] = 1'b1;
    request_queue.push_back(rq);
  endtask

  task automatic push_op(input op_t op, input int c, input int r);
    request_t rq;
    rq = request_t'(REQ_W'({$urandom, $urandom}));
    rq.op = op;
    rq.col = 8'(c);
    rq.row = 8'(r);
    request_queue.push_back(rq);
  endtask

  // Hold until the block has drained every request and result.
  task automatic wait_idle();
    while (request_queue.size() != 0 || pending_responses.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 9'(val);
    case (idx)
      REG_TAP_COUNT: tap_reg = val & 5'h1f;
      REG_FRAME_WIDTH: width_reg = val & 9'h1ff;
      default: height_reg = val & 9'h1ff;
    endcase
  endtask

  task automatic configure(input int unsigned n, input int unsigned w, input int unsigned h);
    write_reg(REG_TAP_COUNT, n);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random requests, mostly reads and pixel loads. A read whose window is
  // not yet known turns into a pixel load at that spot, which fills the
  // frame as the phase runs.
  task automatic random_phase(input int count);
    int made;
    int pick;
    int c;
    int r;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) begin
        c = $urandom_range(0, (eff_w() + 1 > 255) ? 255 : eff_w() + 1);
        r = $urandom_range(0, (eff_h() + 1 > 255) ? 255 : eff_h() + 1);
      end else begin
        c = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
      end
      if (pick < 10) begin
        push_op(OP_NONE, c, r);
      end else begin
        made++;
        if (pick < 55) begin
          if (window_known(c, r)) push_op(OP_READ, c, r);
          else push_pixel(c, r, 8'($urandom));
        end else if (pick < 85) begin
          push_pixel(c, r, 8'($urandom));
        end else begin
          push_tap($urandom_range(0, 3), $urandom_range(0, 31), 16'($urandom));
        end
      end
    end
  endtask

  // Driver: present the head of the queue at the falling edge; hold it
  // until accepted, idle at random as the phase asks.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (request_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      start <= 1'b1;
      request <= request_queue[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: take requests and results at the rising edge.
  always @(posedge clk) begin
    result_t exp_res;
    took = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        took = 1'b1;
        apply_request(request);
        void'(request_queue.pop_front());
      end
      if (done) begin
        if (pending_responses.size() == 0) begin
          report("unexpected result, col", result.out_col, -1);
        end else begin
          exp_res = pending_responses.pop_front();
          if (result.response !== exp_res.response)
            report("response", result.response, exp_res.response);
          if (result.out_col !== exp_res.out_col)
            report("out_col", result.out_col, exp_res.out_col);
          if (result.out_row !== exp_res.out_row)
            report("out_row", result.out_row, exp_res.out_row);
        end
      end
      // Watchdog on cycles with no traffic either way.
      if (took || done) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles > STALL_LIMIT) begin
        $display("timeout waiting for the block");
        $display("tb_separable_gabor_filter: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    errors = 0;
    stall_cycles = 0;
    took = 1'b0;
    tap_reg = 9;
    width_reg = 256;
    height_reg = 256;
    foreach (frame_mem[k]) frame_mem[k] = '0;
    foreach (tap_mem[k]) tap_mem[k] = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part: small 4x3 frame, three taps, extremes of the fields.
    configure(3, 4, 3);
    for (int b = 0; b < 4; b++)
      for (int t = 0; t < NTAPS; t++) push_tap(b, t, 16'($urandom));
    push_tap(0, 0, 16'h8000);
    push_tap(1, 2, 16'h7fff);
    push_tap(2, 1, 16'hffff);
    push_tap(3, 0, 16'h0000);
    push_tap(1, 31, 16'h1234);           // position past the bank: dropped
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) push_pixel(c, r, ((c + r) % 2) ? 8'hff : 8'h00);
    push_pixel(200, 5, 8'h5a);           // outside the frame: dropped
    push_op(OP_NONE, 1, 1);              // unknown op: no result
    push_op(OP_READ, 0, 0);
    push_op(OP_READ, 3, 2);
    push_op(OP_READ, 1, 1);
    push_op(OP_READ, 255, 255);          // outside: zero response
    wait_idle();

    // Random phases over several settings and idle rates.
    idle_pct = 72; configure(9, 10, 8);    random_phase(18); wait_idle();
    idle_pct = 31; configure(31, 12, 12);  random_phase(12); wait_idle();
    idle_pct = 0;  configure(0, 6, 6);     random_phase(9);  wait_idle();
    idle_pct = 72; configure(4, 9, 7);     random_phase(13); wait_idle();
    idle_pct = 0;  configure(5, 256, 1);   random_phase(13); wait_idle();
    idle_pct = 31; configure(7, 1, 256);   random_phase(13); wait_idle();
    idle_pct = 0;  configure(1, 511, 300); random_phase(18); wait_idle();
    idle_pct = 72; configure(9, 0, 5);     random_phase(9);  wait_idle();
    idle_pct = 31; configure(11, 16, 0);   random_phase(7);  wait_idle();
    idle_pct = 0;  configure(13, 16, 16);  random_phase(18); wait_idle();

    repeat (100) @(posedge clk);
    if (errors == 0 && pending_responses.size() == 0) begin
      $display("tb_separable_gabor_filter: PASS");
    end else begin
      $display("tb_separable_gabor_filter: FAIL");
    end
    $finish;
  end

endmodule
